@@ hw/rtl/sgcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seeded grid cell selector package
// Shared types and constants: controller states, the token passed along the
// chain of cells, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package sgcs_pkg;

    localparam int SEED_W  = 64;
    localparam int CELL_W  = 16;
    localparam int COORD_W = 8;
    localparam int COUNT_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_INJECT,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic              valid;
        logic              landed;
        logic [CELL_W-1:0] target;
        logic [CELL_W-1:0] carry;
    } t_token;

endpackage

@@ hw/rtl/seeded_grid_cell_selector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seeded grid cell selector
// Picks pick_count distinct cells of a grid from one 64-bit seed read as a
// mixed-radix number, and reports each pick as a column and a row.
// ----------------------------------------------------------------------------
// Usage:
//   Write grid_columns, grid_rows and pick_count through i_cfg_we, i_cfg_index
//   and i_cfg_data while busy is low. A seed beat is taken at a clock edge
//   with start high and busy low. Each result beat shows on the o_ ports for
//   one cycle with o_valid high; o_last_pick marks the final beat of a seed.
//   A bad configuration gives a single beat with o_bad_config high in the
//   cycle after start, and busy stays low.
//   Each pick runs a 64-step seed division (one quotient bit per cycle), then
//   walks a chain of MAX_PICKS cells and a 16-step coordinate division; the
//   walk and coordinate steps overlap the next seed division, and the seed
//   divider sets the pace of the result beats. A new seed is not taken until
//   the last pick of the previous seed has drained. Reset (synchronous, active
//   low) returns the controller to idle and the configuration registers to 1.
//   The receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module seeded_grid_cell_selector #(
    parameter int MAX_PICKS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [sgcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sgcs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [sgcs_pkg::SEED_W-1:0]         i_seed,
    output logic                                o_valid,
    output logic [sgcs_pkg::COORD_W-1:0]        o_cell_column,
    output logic [sgcs_pkg::COORD_W-1:0]        o_cell_row,
    output logic                                o_last_pick,
    output logic                                o_bad_config
);

    localparam int FILL_W = $clog2(MAX_PICKS + 1);

    sgcs_pkg::t_state                  r_state;
    sgcs_pkg::t_state                  n_state;

    logic [sgcs_pkg::COORD_W-1:0]      r_columns;
    logic [sgcs_pkg::COORD_W-1:0]      r_rows;
    logic [sgcs_pkg::COUNT_W-1:0]      r_pick_count;

    logic [sgcs_pkg::CELL_W-1:0]       r_free;
    logic [sgcs_pkg::CELL_W-1:0]       n_free;
    logic [sgcs_pkg::COUNT_W-1:0]      r_left;
    logic [sgcs_pkg::COUNT_W-1:0]      n_left;
    logic [sgcs_pkg::COUNT_W-1:0]      r_emit_left;
    logic [sgcs_pkg::COUNT_W-1:0]      n_emit_left;
    logic [FILL_W-1:0]                 r_filled;
    logic [FILL_W-1:0]                 n_filled;
    logic                              r_inflight;
    logic                              n_inflight;

    logic                              r_valid;
    logic                              n_valid;
    logic [sgcs_pkg::COORD_W-1:0]      r_col;
    logic [sgcs_pkg::COORD_W-1:0]      n_col;
    logic [sgcs_pkg::COORD_W-1:0]      r_row;
    logic [sgcs_pkg::COORD_W-1:0]      n_row;
    logic                              r_last;
    logic                              n_last;
    logic                              r_bad;
    logic                              n_bad;

    logic [sgcs_pkg::CELL_W-1:0]       w_total;
    logic                              w_bad;

    logic                              w_seed_start;
    logic [sgcs_pkg::SEED_W-1:0]       w_seed_dividend;
    logic [sgcs_pkg::CELL_W-1:0]       w_seed_divisor;
    logic                              w_seed_done;
    logic [sgcs_pkg::SEED_W-1:0]       w_seed_quo;
    logic [sgcs_pkg::CELL_W-1:0]       w_seed_rem;

    logic                              w_coord_start;
    logic                              w_coord_done;
    logic [sgcs_pkg::CELL_W-1:0]       w_coord_quo;
    logic [sgcs_pkg::COORD_W-1:0]      w_coord_rem;

    sgcs_pkg::t_token                  w_inject;
    sgcs_pkg::t_token                  w_tok [MAX_PICKS+1];

    assign w_total = {8'b0, r_columns} * {8'b0, r_rows};
    assign w_bad   = (r_columns == '0) || (w_total == '0) || (r_pick_count == '0) ||
                     ({11'b0, r_pick_count} > 16'(MAX_PICKS)) ||
                     ({11'b0, r_pick_count} > w_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns    <= 8'd1;
            r_rows       <= 8'd1;
            r_pick_count <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgcs_pkg::CFG_GRID_COLUMNS: r_columns    <= i_cfg_data;
                sgcs_pkg::CFG_GRID_ROWS:    r_rows       <= i_cfg_data;
                sgcs_pkg::CFG_PICK_COUNT:   r_pick_count <= i_cfg_data[sgcs_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    sgcs_divider #(
        .DIVIDEND_W (sgcs_pkg::SEED_W),
        .DIVISOR_W  (sgcs_pkg::CELL_W)
    ) u_seed_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_seed_start),
        .i_dividend  (w_seed_dividend),
        .i_divisor   (w_seed_divisor),
        .o_done      (w_seed_done),
        .o_quotient  (w_seed_quo),
        .o_remainder (w_seed_rem)
    );

    sgcs_divider #(
        .DIVIDEND_W (sgcs_pkg::CELL_W),
        .DIVISOR_W  (sgcs_pkg::COORD_W)
    ) u_coord_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_coord_start),
        .i_dividend  (w_tok[MAX_PICKS].target),
        .i_divisor   (r_columns),
        .o_done      (w_coord_done),
        .o_quotient  (w_coord_quo),
        .o_remainder (w_coord_rem)
    );

    assign w_tok[0] = w_inject;

    for (genvar g = 0; g < MAX_PICKS; g++) begin : g_chain
        sgcs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_token    (w_tok[g]),
            .i_occupied (FILL_W'(g) < r_filled),
            .i_tail     (FILL_W'(g) == r_filled),
            .o_token    (w_tok[g+1])
        );
    end

    always_comb begin
        n_state         = r_state;
        n_free          = r_free;
        n_left          = r_left;
        n_emit_left     = r_emit_left;
        n_filled        = r_filled;
        n_inflight      = r_inflight;
        n_valid         = 1'b0;
        n_col           = r_col;
        n_row           = r_row;
        n_last          = r_last;
        n_bad           = r_bad;
        w_seed_start    = 1'b0;
        w_seed_dividend = i_seed;
        w_seed_divisor  = w_total;
        w_coord_start   = 1'b0;
        w_inject        = '0;
        w_inject.target = w_seed_rem;

        if (w_tok[MAX_PICKS].valid) begin
            n_inflight    = 1'b0;
            n_filled      = r_filled + FILL_W'(1);
            w_coord_start = 1'b1;
        end

        if (w_coord_done) begin
            n_valid     = 1'b1;
            n_col       = w_coord_rem;
            n_row       = w_coord_quo[sgcs_pkg::COORD_W-1:0];
            n_last      = (r_emit_left == sgcs_pkg::COUNT_W'(1));
            n_bad       = 1'b0;
            n_emit_left = r_emit_left - sgcs_pkg::COUNT_W'(1);
        end

        case (r_state)
            sgcs_pkg::ST_IDLE: begin
                if (start) begin
                    n_filled = '0;
                    if (w_bad) begin
                        n_valid = 1'b1;
                        n_col   = '0;
                        n_row   = '0;
                        n_last  = 1'b1;
                        n_bad   = 1'b1;
                    end else begin
                        w_seed_start = 1'b1;
                        n_free       = w_total;
                        n_left       = r_pick_count;
                        n_emit_left  = r_pick_count;
                        n_state      = sgcs_pkg::ST_DIVIDE;
                    end
                end
            end
            sgcs_pkg::ST_DIVIDE: begin
                if (w_seed_done) begin
                    n_state = sgcs_pkg::ST_INJECT;
                end
            end
            sgcs_pkg::ST_INJECT: begin
                if (!r_inflight) begin
                    w_inject.valid = 1'b1;
                    n_inflight     = 1'b1;
                    n_left         = r_left - sgcs_pkg::COUNT_W'(1);
                    n_free         = r_free - sgcs_pkg::CELL_W'(1);
                    if (r_left > sgcs_pkg::COUNT_W'(1)) begin
                        w_seed_start    = 1'b1;
                        w_seed_dividend = w_seed_quo;
                        w_seed_divisor  = r_free - sgcs_pkg::CELL_W'(1);
                        n_state         = sgcs_pkg::ST_DIVIDE;
                    end else begin
                        n_state = sgcs_pkg::ST_DRAIN;
                    end
                end
            end
            sgcs_pkg::ST_DRAIN: begin
                if (w_coord_done && (r_emit_left == sgcs_pkg::COUNT_W'(1))) begin
                    n_state = sgcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sgcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sgcs_pkg::ST_IDLE;
            r_left      <= '0;
            r_emit_left <= '0;
            r_filled    <= '0;
            r_inflight  <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_emit_left <= n_emit_left;
            r_filled    <= n_filled;
            r_inflight  <= n_inflight;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free <= n_free;
        r_col  <= n_col;
        r_row  <= n_row;
        r_last <= n_last;
        r_bad  <= n_bad;
    end

    assign busy          = (r_state != sgcs_pkg::ST_IDLE);
    assign o_valid       = r_valid;
    assign o_cell_column = r_col;
    assign o_cell_row    = r_row;
    assign o_last_pick   = r_last;
    assign o_bad_config  = r_bad;

endmodule

@@ hw/rtl/sgcs_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold after the
// done pulse until the next start.
// ----------------------------------------------------------------------------
module sgcs_divider #(
    parameter int DIVIDEND_W = 64,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_count;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_count <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ hw/rtl/sgcs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chosen cell slot
// Holds one chosen cell of the ascending list. A token passing through skips
// over chosen cells no larger than its target, lands in the first larger or
// free slot, and then shifts the displaced entries one slot along.
// ----------------------------------------------------------------------------
module sgcs_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sgcs_pkg::t_token i_token,
    input  logic            i_occupied,
    input  logic            i_tail,
    output sgcs_pkg::t_token o_token
);

    sgcs_pkg::t_token                  r_token;
    sgcs_pkg::t_token                  n_token;
    logic [sgcs_pkg::CELL_W-1:0]       r_value;
    logic [sgcs_pkg::CELL_W-1:0]       n_value;

    always_comb begin
        n_token = i_token;
        n_value = r_value;
        if (i_token.valid) begin
            if (!i_token.landed) begin
                if (i_occupied) begin
                    if (r_value <= i_token.target) begin
                        n_token.target = i_token.target + sgcs_pkg::CELL_W'(1);
                    end else begin
                        n_token.landed = 1'b1;
                        n_token.carry  = r_value;
                        n_value        = i_token.target;
                    end
                end else if (i_tail) begin
                    n_token.landed = 1'b1;
                    n_value        = i_token.target;
                end
            end else begin
                if (i_occupied) begin
                    n_value       = i_token.carry;
                    n_token.carry = r_value;
                end else if (i_tail) begin
                    n_value = i_token.carry;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token.valid <= 1'b0;
        end else begin
            r_token <= n_token;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_token = r_token;

endmodule
